/* sv/aspsq_pkg.sv */
// Shared types, codes and constants of the accelerometer SPI poll sequencer.
package aspsq_pkg;

  typedef enum logic [1:0] {
    CMD_SPI_EVENT = 2'd0,
    CMD_SET_RANGE = 2'd1,
    CMD_SET_RATE  = 2'd2,
    CMD_SET_HBW   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  localparam logic [7:0] SpiCmdWrite  = 8'h0A;
  localparam logic [7:0] SpiCmdRead   = 8'h0B;
  localparam logic [7:0] RegFilterCtl = 8'h2C;
  localparam logic [3:0] FlenTwoByte  = 4'd15;
  localparam logic [3:0] FlenOneByte  = 4'd7;
  localparam int unsigned NumBytes    = 6;
  localparam logic [2:0] LastByteIdx  = 3'd5;
  localparam logic [7:0] PendMax      = 8'hFF;

  typedef struct packed {
    cmd_e       command;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic [2:0] setting_value;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [3:0]  frame_length_code;
    logic        end_of_transfer;
    logic        ignore_receive;
    logic [15:0] tx_payload;
  } tx_frame_t;

  typedef struct packed {
    logic               tx_valid;
    logic [3:0]         frame_length_code;
    logic               end_of_transfer;
    logic               ignore_receive;
    logic [15:0]        tx_payload;
    logic               last_result;
    axis_e              axis_updated;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic signed [15:0] z_sample;
    logic [7:0]         filter_ctl_now;
  } out_item_t;

  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } res_pair_t;

  function automatic logic [7:0] axis_reg(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h0F;
      3'd1:    r = 8'h0E;
      3'd2:    r = 8'h11;
      3'd3:    r = 8'h10;
      3'd4:    r = 8'h13;
      3'd5:    r = 8'h12;
      default: r = 8'h0F;
    endcase
    return r;
  endfunction

endpackage

/* sv/aspsq_if.sv */
// Valid/ready channel interfaces for input and result items.
interface aspsq_in_if;
  logic                valid;
  logic                ready;
  aspsq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aspsq_out_if;
  logic                 valid;
  logic                 ready;
  aspsq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/aspsq_core.sv */
// Sequencer state and next-state logic: sample store, indexes, phases, settings, frames.
module aspsq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  aspsq_pkg::in_item_t  item_i,
  output aspsq_pkg::res_pair_t res_o
);

  logic [7:0] sample_q [aspsq_pkg::NumBytes];
  logic [7:0] sample_d [aspsq_pkg::NumBytes];
  logic [2:0] rx_idx_q, rx_idx_d;
  logic [2:0] cmd_idx_q, cmd_idx_d;
  logic       read_ph_q, read_ph_d;
  logic       write_ph_q, write_ph_d;
  logic [7:0] pend_q, pend_d;
  logic [1:0] range_q, range_d;
  logic       hbw_q, hbw_d;
  logic [2:0] rate_q, rate_d;

  logic [2:0]           rx_ix;
  logic [2:0]           cmd_ix;
  logic [7:0]           pend_inc;
  logic [7:0]           fctl;
  aspsq_pkg::axis_e     axis;
  logic                 a_vld, b_vld;
  aspsq_pkg::tx_frame_t frm_a, frm_b, frm_first;

  assign rx_ix    = (rx_idx_q > aspsq_pkg::LastByteIdx) ? 3'd0 : rx_idx_q;
  assign cmd_ix   = (cmd_idx_q > aspsq_pkg::LastByteIdx) ? 3'd0 : cmd_idx_q;
  assign pend_inc = (pend_q == aspsq_pkg::PendMax) ? pend_q : pend_q + 8'd1;
  assign fctl     = {range_d, 1'b0, hbw_d, 1'b0, rate_d};

  always_comb begin
    sample_d   = sample_q;
    rx_idx_d   = rx_idx_q;
    cmd_idx_d  = cmd_idx_q;
    read_ph_d  = read_ph_q;
    write_ph_d = write_ph_q;
    pend_d     = pend_q;
    range_d    = range_q;
    hbw_d      = hbw_q;
    rate_d     = rate_q;
    axis       = aspsq_pkg::AXIS_NONE;
    a_vld      = 1'b0;
    b_vld      = 1'b0;
    frm_a      = '0;
    frm_b      = '0;
    unique case (item_i.command)
      aspsq_pkg::CMD_SET_RANGE: begin
        range_d = item_i.setting_value[1:0];
        pend_d  = pend_inc;
      end
      aspsq_pkg::CMD_SET_RATE: begin
        rate_d = item_i.setting_value;
        pend_d = pend_inc;
      end
      aspsq_pkg::CMD_SET_HBW: begin
        hbw_d  = item_i.setting_value[0];
        pend_d = pend_inc;
      end
      aspsq_pkg::CMD_SPI_EVENT: begin
        if (item_i.rx_valid) begin
          sample_d[rx_ix] = item_i.rx_byte;
          priority if (rx_ix == 3'd1) begin
            axis = aspsq_pkg::AXIS_X;
          end else if (rx_ix == 3'd3) begin
            axis = aspsq_pkg::AXIS_Y;
          end else if (rx_ix == 3'd5) begin
            axis = aspsq_pkg::AXIS_Z;
          end else begin
            axis = aspsq_pkg::AXIS_NONE;
          end
          rx_idx_d = (rx_ix == aspsq_pkg::LastByteIdx) ? 3'd0 : rx_ix + 3'd1;
        end
        if (item_i.tx_ready) begin
          if (!read_ph_q && (pend_q != 8'd0)) begin
            a_vld = 1'b1;
            if (write_ph_q) begin
              frm_a      = '{1'b1, aspsq_pkg::FlenOneByte, 1'b1, 1'b1, {8'd0, fctl}};
              write_ph_d = 1'b0;
              pend_d     = pend_q - 8'd1;
            end else begin
              frm_a      = '{1'b1, aspsq_pkg::FlenTwoByte, 1'b0, 1'b1,
                             {aspsq_pkg::SpiCmdWrite, aspsq_pkg::RegFilterCtl}};
              write_ph_d = 1'b1;
            end
          end
          if (!write_ph_d) begin
            b_vld = 1'b1;
            if (read_ph_q) begin
              frm_b     = '{1'b1, aspsq_pkg::FlenOneByte, 1'b1, 1'b0, 16'd0};
              read_ph_d = 1'b0;
            end else begin
              frm_b     = '{1'b1, aspsq_pkg::FlenTwoByte, 1'b0, 1'b1,
                            {aspsq_pkg::SpiCmdRead, aspsq_pkg::axis_reg(cmd_ix)}};
              cmd_idx_d = (cmd_ix == aspsq_pkg::LastByteIdx) ? 3'd0 : cmd_ix + 3'd1;
              read_ph_d = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign frm_first = a_vld ? frm_a : frm_b;

  always_comb begin
    res_o.two                     = a_vld && b_vld;
    res_o.first.tx_valid          = frm_first.tx_valid;
    res_o.first.frame_length_code = frm_first.frame_length_code;
    res_o.first.end_of_transfer   = frm_first.end_of_transfer;
    res_o.first.ignore_receive    = frm_first.ignore_receive;
    res_o.first.tx_payload        = frm_first.tx_payload;
    res_o.first.last_result       = !(a_vld && b_vld);
    res_o.first.axis_updated      = axis;
    res_o.first.x_sample          = {sample_d[0], sample_d[1]};
    res_o.first.y_sample          = {sample_d[2], sample_d[3]};
    res_o.first.z_sample          = {sample_d[4], sample_d[5]};
    res_o.first.filter_ctl_now    = fctl;
    res_o.second                  = res_o.first;
    res_o.second.tx_valid          = frm_b.tx_valid;
    res_o.second.frame_length_code = frm_b.frame_length_code;
    res_o.second.end_of_transfer   = frm_b.end_of_transfer;
    res_o.second.ignore_receive    = frm_b.ignore_receive;
    res_o.second.tx_payload        = frm_b.tx_payload;
    res_o.second.last_result       = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aspsq_pkg::NumBytes; i++) begin
        sample_q[i] <= 8'd0;
      end
      rx_idx_q   <= 3'd0;
      cmd_idx_q  <= 3'd0;
      read_ph_q  <= 1'b0;
      write_ph_q <= 1'b0;
      pend_q     <= 8'd0;
      range_q    <= 2'd0;
      hbw_q      <= 1'b1;
      rate_q     <= 3'd3;
    end else if (load_i) begin
      sample_q   <= sample_d;
      rx_idx_q   <= rx_idx_d;
      cmd_idx_q  <= cmd_idx_d;
      read_ph_q  <= read_ph_d;
      write_ph_q <= write_ph_d;
      pend_q     <= pend_d;
      range_q    <= range_d;
      hbw_q      <= hbw_d;
      rate_q     <= rate_d;
    end
  end

endmodule

/* sv/aspsq_obuf.sv */
// Two-slot result register that drains the one or two results of an item.
module aspsq_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  aspsq_pkg::res_pair_t res_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output aspsq_pkg::out_item_t out_item_o,
  output logic                 in_ready_o
);

  logic [1:0]           cnt_q, cnt_d;
  aspsq_pkg::out_item_t slot0_q, slot0_d;
  aspsq_pkg::out_item_t slot1_q, slot1_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i) begin
      cnt_d   = res_i.two ? 2'd2 : 2'd1;
      slot0_d = res_i.first;
      slot1_d = res_i.second;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

/* sv/accel_spi_poll_sequencer.sv */
// Top level of the accelerometer SPI poll sequencer.
// Usage:
//   in_i carries one item per handshake: an SPI event (received byte and/or
//   transmitter ready) or a set-up command for range, output rate or half
//   bandwidth. out_o carries result items: the transmit frame to issue, if
//   any, plus the current axis samples and filter-control value.
//   Each input item gives one result, or two when a tx-ready event finishes
//   a filter-control write and starts the next read; last_result marks the
//   final one.
//   Latency: the first result of an item is valid in the cycle after it is
//   accepted. Throughput: one item per cycle while each item gives one
//   result and out_o.ready is high; a two-result item stalls input until
//   its first result leaves. The two-slot result register sets this rate.
//   Reset clears the sample store, indexes, phases and write queue and loads
//   range 0, half bandwidth 1, rate 3; no result is pending after reset.
//   When the receiver stalls, results hold in the result register and
//   in_i.ready drops until the last pending result can leave.
module accel_spi_poll_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  aspsq_in_if.sink   in_i,
  aspsq_out_if.source out_o
);

  logic                 load;
  logic                 in_ready;
  aspsq_pkg::res_pair_t res;

  assign in_i.ready = in_ready;
  assign load       = in_i.valid && in_ready;

  aspsq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .item_i (in_i.data),
    .res_o  (res)
  );

  aspsq_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.data),
    .in_ready_o  (in_ready)
  );

endmodule

/* sv/aspsq_checker.sv */
// Port-level assertions for the accelerometer SPI poll sequencer, with bind.
module aspsq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic       out_tx_valid_i,
  input logic [3:0] out_flen_i,
  input logic       out_eot_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item gave no result");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_last_i)
    else $error("second result of item missing");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |->
      out_tx_valid_i && (out_flen_i == aspsq_pkg::FlenOneByte) && out_eot_i)
    else $error("non-final result is not a write data frame");

endmodule

bind accel_spi_poll_sequencer aspsq_checker u_aspsq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_last_i     (out_o.data.last_result),
  .out_tx_valid_i (out_o.data.tx_valid),
  .out_flen_i     (out_o.data.frame_length_code),
  .out_eot_i      (out_o.data.end_of_transfer)
);
